// File: hdl/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, register indexes, stage types and helpers for the
// particle speed clamp and drag pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int LANES      = 3;
   localparam int COMP_W     = 32;   // signed Q16.16 component
   localparam int CFG_W      = 31;   // unsigned Q15.16 register
   localparam int FRAC_W     = 16;

   // square root unit
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_REM_W = 34;
   localparam int SQRT_STEPS = ROOT_W;

   // divide unit
   localparam int NUM_W      = 62;
   localparam int DEN_W      = 32;
   localparam int QUOT_W     = 31;

   // drag coefficient and magnitude
   localparam int COEF_W     = 48;
   localparam int MAG_W      = 41;
   localparam logic [MAG_W-1:0] MAG_LIMIT = 41'h100_0000_0000;

   typedef enum logic [2:0] {
      CSR_LINEAR_DRAG    = 3'd0,
      CSR_QUADRATIC_DRAG = 3'd1,
      CSR_MIN_SPEED      = 3'd2,
      CSR_MAX_SPEED      = 3'd3,
      CSR_MAX_SPEED_EN   = 3'd4,
      CSR_BREAK_SPEED    = 3'd5
   } psc_csr_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] vel;
      logic [LANES-1:0][COMP_W-1:0] frc;
   } psc_item_type;

   typedef struct packed {
      psc_item_type      itm;
      logic [DEN_W-1:0]  spd;     // speed after the upper cap
      logic              stop;
      logic              act;     // neither stopped nor zero speed
      logic              do_max;
   } psc_d1_side_type;

   typedef struct packed {
      psc_item_type      itm;     // vel holds the capped velocity
      logic [DEN_W-1:0]  spd;
      logic              stop;
      logic              drag;
      logic              do_min;
   } psc_d2_side_type;

   function automatic logic [COMP_W-1:0] abs_mag(input logic [COMP_W-1:0] v);
      abs_mag = v[COMP_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [COMP_W-1:0] apply_sign(input logic neg,
                                                     input logic [QUOT_W-1:0] q);
      logic [COMP_W-1:0] m;
      m = {1'b0, q};
      apply_sign = neg ? (~m + 1'b1) : m;
   endfunction

endpackage

// File: hdl/psc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module psc_sqrt
   import psc_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output logic [SIDE_W-1:0]  out_side
);

   logic                  vld_ff  [SQRT_STEPS];
   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0]     root_ff [SQRT_STEPS];
   logic [RAD_W-1:0]      rad_ff  [SQRT_STEPS];
   logic [SIDE_W-1:0]     side_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic                  vld_src;
      logic [SQRT_REM_W-1:0] rem_src;
      logic [ROOT_W-1:0]     root_src;
      logic [RAD_W-1:0]      rad_src;
      logic [SIDE_W-1:0]     side_src;
      logic [SQRT_REM_W+1:0] trial_rem;
      logic [SQRT_REM_W+1:0] trial_sub;
      logic                  ge;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         trial_rem = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial_sub = {2'b00, root_src, 2'b01};
         ge        = (trial_rem >= trial_sub);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? SQRT_REM_W'(trial_rem - trial_sub)
                             : SQRT_REM_W'(trial_rem);
            root_ff[k] <= {root_src[ROOT_W-2:0], ge};
            rad_ff[k]  <= {rad_src[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

// File: hdl/psc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. The quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module psc_div
   import psc_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QUOT_W-1:0]  out_quot,
   output logic [SIDE_W-1:0]             out_side
);

   logic                             vld_ff  [QUOT_W];
   logic [LANES-1:0][DEN_W-1:0]      rem_ff  [QUOT_W];
   logic [LANES-1:0][QUOT_W-1:0]     rest_ff [QUOT_W];
   logic [LANES-1:0][QUOT_W-1:0]     quot_ff [QUOT_W];
   logic [DEN_W-1:0]                 den_ff  [QUOT_W];
   logic [SIDE_W-1:0]                side_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic                          vld_src;
      logic [LANES-1:0][DEN_W-1:0]   rem_src;
      logic [LANES-1:0][QUOT_W-1:0]  rest_src;
      logic [LANES-1:0][QUOT_W-1:0]  quot_src;
      logic [DEN_W-1:0]              den_src;
      logic [SIDE_W-1:0]             side_src;
      logic [LANES-1:0][DEN_W-1:0]   rem_in;
      logic [LANES-1:0][QUOT_W-1:0]  quot_in;

      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_src[l]  = {1'b0, in_num[l][NUM_W-1:QUOT_W]};
               rest_src[l] = in_num[l][QUOT_W-1:0];
            end
         end
         assign vld_src  = in_valid;
         assign quot_src = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign rest_src = rest_ff[k-1];
         assign quot_src = quot_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         logic [DEN_W:0] t;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            t          = {rem_src[l], rest_src[l][QUOT_W-1]};
            ge         = (t >= {1'b0, den_src});
            rem_in[l]  = ge ? DEN_W'(t - {1'b0, den_src}) : DEN_W'(t);
            quot_in[l] = {quot_src[l][QUOT_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            for (int l = 0; l < LANES; l++) begin
               rest_ff[k][l] <= {rest_src[l][QUOT_W-2:0], 1'b0};
            end
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

// File: hdl/particle_speed_clamp_drag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_speed_clamp_drag
// Speed clamp and linear plus quadratic drag for a stream of particles.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transaction carries one particle's velocity and force (signed
//   Q16.16). Each rsp_ transaction returns the updated velocity, the force
//   with drag added (saturated) and a stopped flag, in input order.
//   The csr_ port writes the drag coefficients, speed caps and break speed;
//   write it only while no particle is in flight.
// Throughput: one particle per cycle unless the output stalls. The pipeline
//   is 104 register stages deep. The depth is set by the bit-serial square
//   root (32 stages) and the two chained rescale dividers (31 stages each).
// Stall: the whole pipeline advances together; when rsp_valid is high and
//   rsp_ready is low, every stage holds and req_ready drops.
// Reset: clears all valid bits and loads the registers with their defaults
//   (linear drag 1.0, everything else zero).
// ----------------------------------------------------------------------------
module particle_speed_clamp_drag
   import psc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COMP_W-1:0] req_vel_x,
   input  logic signed [COMP_W-1:0] req_vel_y,
   input  logic signed [COMP_W-1:0] req_vel_z,
   input  logic signed [COMP_W-1:0] req_force_x,
   input  logic signed [COMP_W-1:0] req_force_y,
   input  logic signed [COMP_W-1:0] req_force_z,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COMP_W-1:0] rsp_new_vel_x,
   output logic signed [COMP_W-1:0] rsp_new_vel_y,
   output logic signed [COMP_W-1:0] rsp_new_vel_z,
   output logic signed [COMP_W-1:0] rsp_new_force_x,
   output logic signed [COMP_W-1:0] rsp_new_force_y,
   output logic signed [COMP_W-1:0] rsp_new_force_z,
   output logic                     rsp_stopped,
   // register write port
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] lin_drag_ff, quad_drag_ff, min_spd_ff, max_spd_ff, brk_spd_ff;
   logic             max_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_drag_ff  <= CFG_W'(65536);
         quad_drag_ff <= '0;
         min_spd_ff   <= '0;
         max_spd_ff   <= '0;
         max_en_ff    <= 1'b0;
         brk_spd_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINEAR_DRAG:    lin_drag_ff  <= csr_wdata;
            CSR_QUADRATIC_DRAG: quad_drag_ff <= csr_wdata;
            CSR_MIN_SPEED:      min_spd_ff   <= csr_wdata;
            CSR_MAX_SPEED:      max_spd_ff   <= csr_wdata;
            CSR_MAX_SPEED_EN:   max_en_ff    <= csr_wdata[0];
            CSR_BREAK_SPEED:    brk_spd_ff   <= csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Advance every stage unless the output holds an untaken result.
   logic adv;
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   // ------------------------------------------------------------------
   // Stage 0: capture; stage 1: squares; stage 2: sum of squares
   // ------------------------------------------------------------------
   logic                          vld0_ff, vld1_ff, vld2_ff;
   psc_item_type                  itm0_ff, itm1_ff, itm2_ff;
   logic [LANES-1:0][RAD_W-1:0]   sq1_ff;
   logic [RAD_W-1:0]              sum2_ff;
   logic [LANES-1:0][RAD_W-1:0]   sq1_in;

   always_comb begin
      logic [COMP_W-1:0] m;
      for (int i = 0; i < LANES; i++) begin
         m         = abs_mag(itm0_ff.vel[i]);
         sq1_in[i] = RAD_W'(m) * RAD_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm0_ff.vel[0] <= req_vel_x;
         itm0_ff.vel[1] <= req_vel_y;
         itm0_ff.vel[2] <= req_vel_z;
         itm0_ff.frc[0] <= req_force_x;
         itm0_ff.frc[1] <= req_force_y;
         itm0_ff.frc[2] <= req_force_z;
         itm1_ff        <= itm0_ff;
         sq1_ff         <= sq1_in;
         itm2_ff        <= itm1_ff;
         sum2_ff        <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
      end
   end

   // ------------------------------------------------------------------
   // Speed = floor(sqrt(sum))
   // ------------------------------------------------------------------
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   psc_item_type      sq_itm;

   psc_sqrt #(
      .SIDE_W ($bits(psc_item_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld2_ff),
      .in_rad    (sum2_ff),
      .in_side   (itm2_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_itm)
   );

   // ------------------------------------------------------------------
   // Stage 3: stop and upper-cap decision, |v| * max_speed
   // ------------------------------------------------------------------
   logic                          vld3_ff;
   psc_d1_side_type               side3_ff, side3_in;
   logic [DEN_W-1:0]              den3_ff;
   logic [LANES-1:0][NUM_W-1:0]   num3_ff, num3_in;

   always_comb begin
      logic nz;
      logic [COMP_W+CFG_W-1:0] p;
      side3_in.itm    = sq_itm;
      side3_in.stop   = (sq_root < {1'b0, brk_spd_ff});
      nz              = (sq_root != '0);
      side3_in.act    = ~side3_in.stop & nz;
      side3_in.do_max = side3_in.act & max_en_ff & (sq_root > {1'b0, max_spd_ff});
      side3_in.spd    = side3_in.do_max ? {1'b0, max_spd_ff} : sq_root;
      for (int i = 0; i < LANES; i++) begin
         p          = (COMP_W+CFG_W)'(abs_mag(sq_itm.vel[i])) *
                      (COMP_W+CFG_W)'(max_spd_ff);
         num3_in[i] = p[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side3_in;
         den3_ff  <= sq_root;
         num3_ff  <= num3_in;
      end
   end

   logic                          d1_vld;
   logic [LANES-1:0][QUOT_W-1:0]  d1_quot;
   psc_d1_side_type               d1_side;

   psc_div #(
      .SIDE_W ($bits(psc_d1_side_type))
   ) u_div_max (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld3_ff),
      .in_num    (num3_ff),
      .in_den    (den3_ff),
      .in_side   (side3_ff),
      .out_valid (d1_vld),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   // ------------------------------------------------------------------
   // Stage 4: apply upper cap, lower-cap decision, |v1| * min_speed
   // ------------------------------------------------------------------
   logic                          vld4_ff;
   psc_d2_side_type               side4_ff, side4_in;
   logic [LANES-1:0][NUM_W-1:0]   num4_ff, num4_in;

   always_comb begin
      logic [COMP_W-1:0]       m1;
      logic [COMP_W+CFG_W-1:0] p;
      side4_in.itm    = d1_side.itm;
      side4_in.spd    = d1_side.spd;
      side4_in.stop   = d1_side.stop;
      side4_in.drag   = d1_side.act & (d1_side.spd != '0);
      side4_in.do_min = side4_in.drag & (d1_side.spd < {1'b0, min_spd_ff});
      for (int i = 0; i < LANES; i++) begin
         if (d1_side.do_max) begin
            side4_in.itm.vel[i] = apply_sign(d1_side.itm.vel[i][COMP_W-1], d1_quot[i]);
            m1                  = {1'b0, d1_quot[i]};
         end else begin
            m1                  = abs_mag(d1_side.itm.vel[i]);
         end
         p          = (COMP_W+CFG_W)'(m1) * (COMP_W+CFG_W)'(min_spd_ff);
         num4_in[i] = p[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff <= side4_in;
         num4_ff  <= num4_in;
      end
   end

   logic                          d2_vld;
   logic [LANES-1:0][QUOT_W-1:0]  d2_quot;
   psc_d2_side_type               d2_side;

   psc_div #(
      .SIDE_W ($bits(psc_d2_side_type))
   ) u_div_min (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld4_ff),
      .in_num    (num4_ff),
      .in_den    (side4_ff.spd),
      .in_side   (side4_ff),
      .out_valid (d2_vld),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   // ------------------------------------------------------------------
   // Stage 5: apply lower cap, k2 * speed
   // Stage 6: drag coefficient
   // Stage 7: |v| * coefficient in two partial products
   // Stage 8: drag magnitude with clamp
   // Stage 9: saturating add, output register
   // ------------------------------------------------------------------
   logic                               vld5_ff, vld6_ff, vld7_ff, vld8_ff;
   psc_item_type                       itm5_ff, itm6_ff, itm7_ff, itm8_ff, itm5_in;
   logic                               stop5_ff, stop6_ff, stop7_ff, stop8_ff;
   logic                               drag5_ff, drag6_ff, drag7_ff, drag8_ff;
   logic [LANES-1:0][COMP_W-1:0]       mag5_ff, mag6_ff, mag5_in;
   logic [DEN_W+CFG_W-1:0]             prodk5_ff, prodk5_in;
   logic [COEF_W-1:0]                  coef6_ff;
   logic [LANES-1:0][2*COMP_W-1:0]     plo7_ff, plo7_in;
   logic [LANES-1:0][COMP_W+15:0]      phi7_ff, phi7_in;
   logic [LANES-1:0][MAG_W-1:0]        mag8_ff, mag8_in;

   always_comb begin
      logic [DEN_W-1:0] s2;
      itm5_in = d2_side.itm;
      for (int i = 0; i < LANES; i++) begin
         if (d2_side.do_min) begin
            itm5_in.vel[i] = apply_sign(d2_side.itm.vel[i][COMP_W-1], d2_quot[i]);
            mag5_in[i]     = {1'b0, d2_quot[i]};
         end else begin
            mag5_in[i]     = abs_mag(d2_side.itm.vel[i]);
         end
      end
      s2        = d2_side.do_min ? {1'b0, min_spd_ff} : d2_side.spd;
      prodk5_in = (DEN_W+CFG_W)'(s2) * (DEN_W+CFG_W)'(quad_drag_ff);
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         plo7_in[i] = (2*COMP_W)'(mag6_ff[i]) * (2*COMP_W)'(coef6_ff[COMP_W-1:0]);
         phi7_in[i] = (COMP_W+16)'(mag6_ff[i]) *
                      (COMP_W+16)'(coef6_ff[COEF_W-1:COMP_W]);
      end
   end

   always_comb begin
      logic [MAG_W+7:0] s;
      for (int i = 0; i < LANES; i++) begin
         s = {9'b0, phi7_ff[i][23:0], 16'b0} + (MAG_W+8)'(plo7_ff[i][2*COMP_W-1:FRAC_W]);
         if (phi7_ff[i] >= (COMP_W+16)'(1 << 24)) begin
            mag8_in[i] = MAG_LIMIT;
         end else if (s > (MAG_W+8)'(MAG_LIMIT)) begin
            mag8_in[i] = MAG_LIMIT;
         end else begin
            mag8_in[i] = s[MAG_W-1:0];
         end
      end
   end

   logic                          vld9_ff;
   logic [LANES-1:0][COMP_W-1:0]  vel9_ff, vel9_in, frc9_ff, frc9_in;
   logic                          stop9_ff;

   always_comb begin
      logic signed [MAG_W:0] f, m, r;
      for (int i = 0; i < LANES; i++) begin
         f = (MAG_W+1)'($signed(itm8_ff.frc[i]));
         m = $signed({1'b0, mag8_ff[i]});
         r = itm8_ff.vel[i][COMP_W-1] ? (f + m) : (f - m);
         vel9_in[i] = stop8_ff ? '0 : itm8_ff.vel[i];
         if (!drag8_ff) begin
            frc9_in[i] = itm8_ff.frc[i];
         end else if (r > (MAG_W+1)'(32'sh7FFF_FFFF)) begin
            frc9_in[i] = 32'h7FFF_FFFF;
         end else if (r < -(MAG_W+1)'(33'sh0_8000_0000)) begin
            frc9_in[i] = 32'h8000_0000;
         end else begin
            frc9_in[i] = r[COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         itm5_ff   <= itm5_in;
         mag5_ff   <= mag5_in;
         prodk5_ff <= prodk5_in;
         stop5_ff  <= d2_side.stop;
         drag5_ff  <= d2_side.drag;

         itm6_ff   <= itm5_ff;
         mag6_ff   <= mag5_ff;
         coef6_ff  <= COEF_W'(lin_drag_ff) + COEF_W'(prodk5_ff[DEN_W+CFG_W-1:FRAC_W]);
         stop6_ff  <= stop5_ff;
         drag6_ff  <= drag5_ff;

         itm7_ff   <= itm6_ff;
         plo7_ff   <= plo7_in;
         phi7_ff   <= phi7_in;
         stop7_ff  <= stop6_ff;
         drag7_ff  <= drag6_ff;

         itm8_ff   <= itm7_ff;
         mag8_ff   <= mag8_in;
         stop8_ff  <= stop7_ff;
         drag8_ff  <= drag7_ff;

         vel9_ff   <= vel9_in;
         frc9_ff   <= frc9_in;
         stop9_ff  <= stop8_ff;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
         vld9_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= sq_vld;
         vld4_ff <= d1_vld;
         vld5_ff <= d2_vld;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
         vld9_ff <= vld8_ff;
      end
   end

   assign rsp_valid       = vld9_ff;
   assign rsp_new_vel_x   = vel9_ff[0];
   assign rsp_new_vel_y   = vel9_ff[1];
   assign rsp_new_vel_z   = vel9_ff[2];
   assign rsp_new_force_x = frc9_ff[0];
   assign rsp_new_force_y = frc9_ff[1];
   assign rsp_new_force_z = frc9_ff[2];
   assign rsp_stopped     = stop9_ff;

endmodule
